FILE: sv/stl_pkg.sv
`timescale 1ns / 1ps
// stl_pkg: token kind codes, character codes, operator and keyword tables
// and the push control struct shared by the lexer modules
// depends on nothing
package stl_pkg;

    // token kinds; 0..9 are the operators in table order
    localparam logic [4:0] KIND_EOF      = 5'd10;
    localparam logic [4:0] KIND_NEWLINE  = 5'd11;
    localparam logic [4:0] KIND_STRING   = 5'd12;
    localparam logic [4:0] KIND_INTEGER  = 5'd13;
    localparam logic [4:0] KIND_IDENT    = 5'd14;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd15;
    localparam logic [4:0] KIND_ERROR    = 5'd24;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam int NUM_OPS      = 10;
    localparam int NUM_KEYWORDS = 9;
    localparam int KW_TEXT_LEN  = 6;

    localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h2C, 8'h28, 8'h29, 8'h3C, 8'h3E
    };

    // keyword spellings, zero padded
    localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KW_TEXT_LEN] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"g", "e", "t", 8'h00, 8'h00, 8'h00},
        '{"p", "o", "s", "t", 8'h00, 8'h00},
        '{"p", "u", "t", 8'h00, 8'h00, 8'h00},
        '{"d", "e", "l", "e", "t", "e"},
        '{"p", "r", "i", "n", "t", 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd4, 3'd3, 3'd6, 3'd5
    };

    typedef struct packed {
        logic push0;
        logic push1;
    } t_push_ctl;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

endpackage

FILE: sv/stl_if.sv
`timescale 1ns / 1ps
// stl_byte_if and stl_token_if: valid/ready channels for source bytes and tokens
// depends on nothing
interface stl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface stl_token_if #(
    parameter int LENGTH_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             token_kind;
    logic [31:0]            start_offset;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_offset,
                  input token_length, input last_of_run, output ready);
endinterface

FILE: sv/script_token_lexer.sv
`timescale 1ns / 1ps
// script_token_lexer: byte-stream tokenizer, top level
// a byte is registered when it is accepted; once its tokens fit they are
//   written to the output queue behind any words still waiting there
// throughput: one byte per cycle; the queue drains one word per cycle of ready, so a byte
//   stalls only while the queue has no room for its tokens (two-token bytes add backlog)
module script_token_lexer #(
    parameter int KEYWORD_MAX_LEN = 6,
    parameter int LENGTH_BITS     = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stl_byte_if.sink   i_char,
    stl_token_if.source o_token
);
    import stl_pkg::*;

    // reset: synchronous, active low; clears scan mode, position and queue occupancy

    // token word: kind, start offset, length, last-of-run flag
    localparam int TOKEN_W = 5 + 32 + LENGTH_BITS + 1;

    t_push_ctl          w_push;
    logic [TOKEN_W-1:0] w_tok0;
    logic [TOKEN_W-1:0] w_tok1;
    logic [1:0]         w_free;
    logic [TOKEN_W-1:0] w_head;

    // scan state, keyword prefix and the per-byte lexer step
    stl_core #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_char.valid),
        .i_char_in (i_char.char_in),
        .o_ready   (i_char.ready),
        .i_free    (w_free),
        .o_push    (w_push),
        .o_tok0    (w_tok0),
        .o_tok1    (w_tok1)
    );

    // result register pair; a byte only steps when its tokens fit
    stl_out_queue #(
        .WIDTH (TOKEN_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data0 (w_tok0),
        .i_data1 (w_tok1),
        .o_free  (w_free),
        .o_valid (o_token.valid),
        .i_ready (o_token.ready),
        .o_data  (w_head)
    );

    // unpack the head word
    assign o_token.token_kind   = w_head[TOKEN_W-1 -: 5];
    assign o_token.start_offset = w_head[LENGTH_BITS+32 : LENGTH_BITS+1];
    assign o_token.token_length = w_head[LENGTH_BITS : 1];
    assign o_token.last_of_run  = w_head[0];

`ifndef NO_ASSERTIONS
    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_token.valid)
        else $error("token queue not empty after reset");

    // a second token is only pushed together with a first one
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push1 |-> w_push.push0)
        else $error("second token pushed without first");

    // the rest of a run is already queued when its first word leaves
    a_run_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid && o_token.ready && !o_token.last_of_run |=> o_token.valid)
        else $error("token run split by a gap");

    // end of file always closes its run and is one byte long
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid && (o_token.token_kind == KIND_EOF) |->
            o_token.last_of_run && (o_token.token_length == LENGTH_BITS'(1)))
        else $error("malformed end-of-file token");
`endif

endmodule

FILE: sv/stl_core.sv
`timescale 1ns / 1ps
// stl_core: input byte register, scan state and the one-byte lexer step
// depends on stl_pkg
module stl_core #(
    parameter int KEYWORD_MAX_LEN = 6,
    parameter int LENGTH_BITS     = 16,
    localparam int TOKEN_W        = 5 + 32 + LENGTH_BITS + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_char_in,
    output logic                 o_ready,
    input  logic [1:0]           i_free,
    output stl_pkg::t_push_ctl   o_push,
    output logic [TOKEN_W-1:0]   o_tok0,
    output logic [TOKEN_W-1:0]   o_tok1
);
    import stl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_STR,
        MODE_SWALLOW
    } t_mode;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    t_mode                  r_mode, n_mode;
    logic [31:0]            r_pstart, n_pstart;
    logic [LENGTH_BITS-1:0] r_plen, n_plen;
    logic [31:0]            r_pos, n_pos;
    logic [7:0]             r_prefix [KEYWORD_MAX_LEN];

    logic [7:0] c;
    assign c = r_in_byte;

    // byte handling in idle mode
    logic                   e_valid;
    logic [4:0]             e_kind;
    logic [LENGTH_BITS-1:0] e_len;
    t_mode                  e_mode;
    logic                   e_open;
    logic                   e_restart;
    logic                   op_hit;
    logic [4:0]             op_kind;

    always_comb begin
        op_hit  = 1'b0;
        op_kind = 5'd0;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (c == OP_CHARS[i]) begin
                op_hit  = 1'b1;
                op_kind = 5'(i);
            end
        end
    end

    always_comb begin
        e_valid   = 1'b0;
        e_kind    = KIND_ERROR;
        e_len     = LEN_ONE;
        e_mode    = MODE_IDLE;
        e_open    = 1'b0;
        e_restart = 1'b0;
        priority if (c == CH_SPACE) begin
            e_valid = 1'b0;
        end else if (op_hit) begin
            e_valid = 1'b1;
            e_kind  = op_kind;
        end else if (c == CH_NUL) begin
            e_valid   = 1'b1;
            e_kind    = KIND_EOF;
            e_restart = 1'b1;
        end else if (c == CH_NL) begin
            e_valid = 1'b1;
            e_kind  = KIND_NEWLINE;
        end else if (c == CH_CR) begin
            e_valid = 1'b1;
            e_kind  = KIND_NEWLINE;
            e_len   = LEN_TWO;
            e_mode  = MODE_SWALLOW;
        end else if (c == CH_QUOTE) begin
            e_mode = MODE_STR;
            e_open = 1'b1;
        end else if (is_digit(c)) begin
            e_mode = MODE_NUM;
            e_open = 1'b1;
        end else if (is_ident_start(c)) begin
            e_mode = MODE_IDENT;
            e_open = 1'b1;
        end else begin
            e_valid = 1'b1;
        end
    end

    // keyword lookup on the stored prefix
    logic [4:0] kw_kind;
    logic       kw_match;

    always_comb begin
        kw_kind = KIND_IDENT;
        for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
            kw_match = (r_plen == LENGTH_BITS'(KW_LEN[i]));
            for (int j = 0; j < KW_TEXT_LEN; j++) begin
                kw_match = kw_match && (r_prefix[j] == KW_TEXT[i][j]);
            end
            for (int j = KW_TEXT_LEN; j < KEYWORD_MAX_LEN; j++) begin
                kw_match = kw_match && (r_prefix[j] == CH_NUL);
            end
            if (kw_match) begin
                kw_kind = KIND_KEYWORD0 + 5'(i);
            end
        end
    end

    logic [LENGTH_BITS-1:0] grown;
    assign grown = (r_plen == LEN_MAX) ? r_plen : r_plen + LEN_ONE;

    // main step
    logic                   f_valid;
    logic [4:0]             f_kind;
    logic [LENGTH_BITS-1:0] f_len;
    logic                   use_e;
    logic                   pfx_wr;
    logic                   pfx_init;
    logic                   restart;

    always_comb begin
        f_valid  = 1'b0;
        f_kind   = KIND_INTEGER;
        f_len    = r_plen;
        use_e    = 1'b0;
        pfx_wr   = 1'b0;
        n_mode   = r_mode;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        unique case (r_mode)
            MODE_NUM: begin
                if (is_digit(c) || (c == CH_MINUS)) begin
                    n_plen = grown;
                end else begin
                    f_valid = 1'b1;
                    use_e   = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_ident_start(c) || is_digit(c)) begin
                    n_plen = grown;
                    pfx_wr = 1'b1;
                end else begin
                    f_valid = 1'b1;
                    f_kind  = kw_kind;
                    use_e   = 1'b1;
                end
            end
            MODE_STR: begin
                if (c == CH_NUL) begin
                    f_valid = 1'b1;
                    f_kind  = KIND_ERROR;
                    use_e   = 1'b1;
                end else begin
                    n_plen = grown;
                    if (c == CH_QUOTE) begin
                        f_valid = 1'b1;
                        f_kind  = KIND_STRING;
                        f_len   = grown;
                        n_mode  = MODE_IDLE;
                    end
                end
            end
            MODE_SWALLOW: begin
                n_mode = MODE_IDLE;
                use_e  = (c == CH_NUL);
            end
            default: begin
                use_e = 1'b1;
            end
        endcase
        if (use_e) begin
            n_mode = e_mode;
            if (e_open) begin
                n_pstart = r_pos;
                n_plen   = LEN_ONE;
            end
        end
        pfx_init = use_e && e_open && (e_mode == MODE_IDENT);
        restart  = use_e && e_restart;
    end

    assign n_pos = restart ? 32'd0 : r_pos + 32'd1;

    // output tokens and flow control
    logic       second;
    logic [1:0] ntok;
    logic       fire;

    assign second = f_valid && use_e && e_valid;
    assign ntok   = 2'(f_valid) + 2'(use_e && e_valid);
    assign fire   = r_in_valid && (ntok <= i_free);

    assign o_ready = !r_in_valid || fire;

    assign o_tok0 = f_valid ? {f_kind, r_pstart, f_len, !second}
                            : {e_kind, r_pos, e_len, 1'b1};
    assign o_tok1 = {e_kind, r_pos, e_len, 1'b1};

    assign o_push.push0 = fire && (ntok != 2'd0);
    assign o_push.push1 = fire && (ntok == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_pstart   <= 32'd0;
            r_plen     <= '0;
            r_pos      <= 32'd0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_mode   <= n_mode;
                r_pstart <= n_pstart;
                r_plen   <= n_plen;
                r_pos    <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_char_in;
        end
        if (fire) begin
            if (pfx_init) begin
                for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                    r_prefix[j] <= (j == 0) ? c : CH_NUL;
                end
            end else if (pfx_wr) begin
                for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                    if (r_plen == LENGTH_BITS'(j)) begin
                        r_prefix[j] <= c;
                    end
                end
            end
        end
    end

endmodule

FILE: sv/stl_out_queue.sv
`timescale 1ns / 1ps
// stl_out_queue: two-entry token queue, up to two pushes and one pop per cycle
// depends on stl_pkg
module stl_out_queue #(
    parameter int WIDTH = 54
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stl_pkg::t_push_ctl i_push,
    input  logic [WIDTH-1:0]   i_data0,
    input  logic [WIDTH-1:0]   i_data1,
    output logic [1:0]         o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WIDTH-1:0]   o_data
);
    import stl_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    logic [1:0]       r_cnt, n_cnt, cnt_s;
    logic [WIDTH-1:0] r_q0, r_q1, n_q0, n_q1;
    logic             pop;

    assign pop    = (r_cnt != 2'd0) && i_ready;
    assign cnt_s  = r_cnt - {1'b0, pop};
    assign o_free = DEPTH - cnt_s;
    assign n_cnt  = cnt_s + 2'(i_push.push0) + 2'(i_push.push1);

    always_comb begin
        n_q0 = pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        if (i_push.push0) begin
            if (cnt_s == 2'd0) begin
                n_q0 = i_data0;
            end else begin
                n_q1 = i_data0;
            end
        end
        if (i_push.push1) begin
            n_q1 = i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;

endmodule

FILE: bench/script_token_lexer_checker.sv
`timescale 1ns / 1ps
// script_token_lexer_checker: watches the byte and token channels, predicts the
// tokens of every accepted byte and compares them in order with what comes out
// depends on stl_pkg
module script_token_lexer_checker #(
    parameter int KEYWORD_MAX_LEN = 6,
    parameter int LENGTH_BITS     = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_byte_valid,
    input  logic                   i_byte_ready,
    input  logic [7:0]             i_byte,
    input  logic                   i_tok_valid,
    input  logic                   i_tok_ready,
    input  logic [4:0]             i_tok_kind,
    input  logic [31:0]            i_tok_start,
    input  logic [LENGTH_BITS-1:0] i_tok_length,
    input  logic                   i_tok_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_keywords
);
    import stl_pkg::*;

    typedef struct packed {
        logic [4:0]             kind;
        logic [31:0]            start;
        logic [LENGTH_BITS-1:0] len;
        logic                   last;
    } t_token;

    typedef enum logic [2:0] {
        SCAN_IDLE    = 3'd0,
        SCAN_NUMBER  = 3'd1,
        SCAN_IDENT   = 3'd2,
        SCAN_STRING  = 3'd3,
        SCAN_SWALLOW = 3'd4
    } t_scan_mode;

    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TOP = {LENGTH_BITS{1'b1}};

    // lexer state as the predictor sees it
    t_scan_mode             mode;
    logic [31:0]            word_start;
    logic [LENGTH_BITS-1:0] word_len;
    logic [7:0]             word_head [KEYWORD_MAX_LEN];
    logic [31:0]            next_offset;

    t_token expected_tokens [$];
    t_token byte_tokens [$];

    function automatic logic decimal_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == 8'h5F);
    endfunction

    task automatic note_token(input logic [4:0] kind, input logic [31:0] start,
                              input logic [LENGTH_BITS-1:0] len);
        t_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        byte_tokens.push_back(t);
    endtask

    task automatic extend_word();
        if (word_len != LEN_TOP) begin
            word_len = word_len + LEN_ONE;
        end
    endtask

    // pending number or identifier ends; identifiers get the keyword lookup
    task automatic close_word();
        logic [4:0] kind;
        logic       hit;
        kind = KIND_INTEGER;
        if (mode == SCAN_IDENT) begin
            kind = KIND_IDENT;
            if (word_len <= LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
                for (int i = 0; i < NUM_KEYWORDS; i++) begin
                    if (kind == KIND_IDENT && word_len == LENGTH_BITS'(KW_LEN[i])) begin
                        hit = 1'b1;
                        for (int j = 0; j < int'(KW_LEN[i]); j++) begin
                            if (word_head[j] != KW_TEXT[i][j]) begin
                                hit = 1'b0;
                            end
                        end
                        if (hit) begin
                            kind = KIND_KEYWORD0 + 5'(i);
                        end
                    end
                end
            end
        end
        note_token(kind, word_start, word_len);
        mode = SCAN_IDLE;
    endtask

    // a byte seen between tokens
    task automatic scan_idle(input logic [7:0] c, input logic [31:0] at,
                             output logic restart);
        logic matched;
        restart = 1'b0;
        matched = 1'b0;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (!matched && OP_CHARS[i] == c) begin
                note_token(5'(i), at, LEN_ONE);
                matched = 1'b1;
            end
        end
        if (matched || c == CH_SPACE) begin
        end else if (c == CH_NUL) begin
            note_token(KIND_EOF, at, LEN_ONE);
            mode    = SCAN_IDLE;
            restart = 1'b1;
        end else if (c == CH_NL) begin
            note_token(KIND_NEWLINE, at, LEN_ONE);
        end else if (c == CH_CR) begin
            note_token(KIND_NEWLINE, at, LENGTH_BITS'(2));
            mode = SCAN_SWALLOW;
        end else if (c == CH_QUOTE) begin
            mode       = SCAN_STRING;
            word_start = at;
            word_len   = LEN_ONE;
        end else if (decimal_char(c)) begin
            mode       = SCAN_NUMBER;
            word_start = at;
            word_len   = LEN_ONE;
        end else if (name_char(c)) begin
            mode       = SCAN_IDENT;
            word_start = at;
            word_len   = LEN_ONE;
            for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                word_head[i] = 8'h00;
            end
            word_head[0] = c;
        end else begin
            note_token(KIND_ERROR, at, LEN_ONE);
        end
    endtask

    task automatic lex_byte(input logic [7:0] c);
        logic [31:0] at;
        logic        restart;
        logic        to_idle;
        t_token      t;
        int          n;
        at      = next_offset;
        restart = 1'b0;
        to_idle = 1'b0;
        case (mode)
            SCAN_NUMBER: begin
                if (decimal_char(c) || c == CH_MINUS) begin
                    extend_word();
                end else begin
                    close_word();
                    to_idle = 1'b1;
                end
            end
            SCAN_IDENT: begin
                if (name_char(c) || decimal_char(c)) begin
                    if (word_len < LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
                        word_head[word_len] = c;
                    end
                    extend_word();
                end else begin
                    close_word();
                    to_idle = 1'b1;
                end
            end
            SCAN_STRING: begin
                if (c == CH_NUL) begin
                    note_token(KIND_ERROR, word_start, word_len);
                    mode    = SCAN_IDLE;
                    to_idle = 1'b1;
                end else begin
                    extend_word();
                    if (c == CH_QUOTE) begin
                        note_token(KIND_STRING, word_start, word_len);
                        mode = SCAN_IDLE;
                    end
                end
            end
            SCAN_SWALLOW: begin
                mode    = SCAN_IDLE;
                to_idle = (c == CH_NUL);
            end
            default: begin
                mode    = SCAN_IDLE;
                to_idle = 1'b1;
            end
        endcase
        if (to_idle) begin
            scan_idle(c, at, restart);
        end
        next_offset = restart ? 32'd0 : at + 32'd1;
        n = byte_tokens.size();
        for (int i = 0; i < n; i++) begin
            t      = byte_tokens.pop_front();
            t.last = (i == n - 1);
            expected_tokens.push_back(t);
        end
    endtask

    task automatic report_fault(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_token want;
        t_token got;
        if (!i_rst_n) begin
            mode        = SCAN_IDLE;
            word_start  = 32'd0;
            word_len    = '0;
            next_offset = 32'd0;
            for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                word_head[i] = 8'h00;
            end
            expected_tokens.delete();
            byte_tokens.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_keywords   = 0;
        end else begin
            // outgoing word first; a byte's own tokens never leave at its accept edge
            if (i_tok_valid && i_tok_ready) begin
                got.kind  = i_tok_kind;
                got.start = i_tok_start;
                got.len   = i_tok_length;
                got.last  = i_tok_last;
                if (expected_tokens.size() == 0) begin
                    report_fault($sformatf("unexpected token kind %0d start %0d len %0d last %0b",
                        got.kind, got.start, got.len, got.last));
                end else begin
                    want = expected_tokens.pop_front();
                    o_checked++;
                    if (want.kind >= KIND_KEYWORD0 && want.kind < KIND_ERROR) begin
                        o_keywords++;
                    end
                    if (want !== got) begin
                        report_fault($sformatf({"expected kind %0d start %0d len %0d last %0b,",
                            " got kind %0d start %0d len %0d last %0b"},
                            want.kind, want.start, want.len, want.last,
                            got.kind, got.start, got.len, got.last));
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                lex_byte(i_byte);
            end
        end
        o_pending = expected_tokens.size();
    end

endmodule

FILE: bench/script_token_lexer_tb.sv
`timescale 1ns / 1ps
// script_token_lexer_tb: drives source bytes into the lexer, drains its tokens
// with random stalls and gives the verdict from the checker's failure and pending counts
// depends on stl_pkg, stl_if, script_token_lexer and script_token_lexer_checker
module script_token_lexer_tb;
    import stl_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;

    logic i_clk;
    logic i_rst_n;

    stl_byte_if                         byte_if ();
    stl_token_if #(.LENGTH_BITS(16))    token_if ();

    int   fails;
    int   pending;
    int   checked;
    int   keywords;
    int   cycles;
    int   random_items;
    int   bytes_sent;
    logic calm;            // no idling on either side
    logic pressure_on;     // asks the sink for its long hold-off
    logic pressure_done;   // owned by the sink process
    logic [7:0] src_q [$];

    script_token_lexer #(
        .KEYWORD_MAX_LEN(6),
        .LENGTH_BITS(16)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (byte_if),
        .o_token (token_if)
    );

    script_token_lexer_checker #(
        .KEYWORD_MAX_LEN(6),
        .LENGTH_BITS(16)
    ) token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_if.valid),
        .i_byte_ready (byte_if.ready),
        .i_byte       (byte_if.char_in),
        .i_tok_valid  (token_if.valid),
        .i_tok_ready  (token_if.ready),
        .i_tok_kind   (token_if.token_kind),
        .i_tok_start  (token_if.start_offset),
        .i_tok_length (token_if.token_length),
        .i_tok_last   (token_if.last_of_run),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_keywords   (keywords)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // guard against a hung handshake
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("script_token_lexer regression: fail");
            $finish;
        end
    end

    // token sink: random stalls, a calm stretch, and one long hold-off
    initial begin : token_sink
        int hold_left;
        hold_left      = 0;
        pressure_done  = 1'b0;
        token_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_on && !pressure_done && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                token_if.ready <= 1'b0;
                hold_left--;
                if (hold_left == 0) begin
                    pressure_done = 1'b1;
                end
            end else if (calm) begin
                token_if.ready <= 1'b1;
            end else begin
                token_if.ready <= ($urandom_range(99) >= 18);
            end
        end
    end

    // every queued byte is one word on the input, spaces and swallowed bytes too
    task automatic keep(input logic [7:0] b);
        src_q.push_back(b);
        random_items++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            src_q.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26) begin
            return 8'h61 + 8'(r);
        end else if (r < 52) begin
            return 8'h41 + 8'(r - 26);
        end
        return 8'h5F;
    endfunction

    function automatic logic [7:0] pick_tail();
        if ($urandom_range(3) == 0) begin
            return 8'h30 + 8'($urandom_range(9));
        end
        return pick_letter();
    endfunction

    // byte that ends a word: space, operator, newline or end of source
    function automatic logic [7:0] pick_break();
        int r;
        r = $urandom_range(5);
        if (r < 3) begin
            return CH_SPACE;
        end else if (r == 3) begin
            return OP_CHARS[$urandom_range(NUM_OPS - 1)];
        end else if (r == 4) begin
            return CH_NL;
        end
        return CH_NUL;
    endfunction

    // one lexeme, mostly well formed, with some noise and broken pieces
    task automatic add_lexeme();
        int         pick;
        int         n;
        int         k;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // exact keywords, and near misses: truncated, extended, capitalized
            k = $urandom_range(NUM_KEYWORDS - 1);
            n = int'(KW_LEN[k]);
            if (pick >= 20 && $urandom_range(1) == 1) begin
                n = n - 1;
            end
            for (int j = 0; j < n; j++) begin
                b = KW_TEXT[k][j];
                if (pick >= 20 && j == 0 && $urandom_range(3) == 0) begin
                    b = b - 8'h20;
                end
                keep(b);
            end
            if (pick >= 20 && $urandom_range(1) == 1) begin
                keep(pick_tail());
            end
            keep(pick_break());
        end else if (pick < 45) begin
            n = $urandom_range(9, 1);
            keep(pick_letter());
            for (int j = 1; j < n; j++) begin
                keep(pick_tail());
            end
        end else if (pick < 55) begin
            n = $urandom_range(6, 1);
            keep(8'h30 + 8'($urandom_range(9)));
            for (int j = 1; j < n; j++) begin
                if ($urandom_range(3) == 0) begin
                    keep(CH_MINUS);
                end else begin
                    keep(8'h30 + 8'($urandom_range(9)));
                end
            end
        end else if (pick < 65) begin
            // string body takes any byte but NUL and quote; some stay open
            keep(CH_QUOTE);
            n = $urandom_range(6);
            for (int j = 0; j < n; j++) begin
                b = 8'($urandom_range(255, 1));
                while (b == CH_QUOTE) begin
                    b = 8'($urandom_range(255, 1));
                end
                keep(b);
            end
            if ($urandom_range(9) != 0) begin
                keep(CH_QUOTE);
            end
        end else if (pick < 75) begin
            keep(OP_CHARS[$urandom_range(NUM_OPS - 1)]);
        end else if (pick < 80) begin
            if ($urandom_range(1) == 1) begin
                keep(CH_NL);
            end else begin
                keep(CH_CR);
                // swallowed byte is ignored unless it ends the source
                b = ($urandom_range(4) == 0) ? CH_NUL : 8'($urandom_range(255));
                keep(b);
            end
        end else if (pick < 87) begin
            n = $urandom_range(3, 1);
            for (int j = 0; j < n; j++) begin
                keep(CH_SPACE);
            end
        end else if (pick < 91) begin
            keep(CH_NUL);
        end else begin
            keep(8'($urandom_range(255)));
        end
    endtask

    // offer queued bytes one word at a time, idling at random between them
    task automatic drain_source();
        logic [7:0] b;
        while (src_q.size() > 0) begin
            b = src_q.pop_front();
            while (!calm && $urandom_range(99) < 18) begin
                byte_if.valid <= 1'b0;
                @(posedge i_clk);
            end
            byte_if.valid   <= 1'b1;
            byte_if.char_in <= b;
            @(posedge i_clk);
            while (!byte_if.ready) begin
                @(posedge i_clk);
            end
            bytes_sent++;
        end
    endtask

    initial begin : stimulus
        byte_if.valid    <= 1'b0;
        byte_if.char_in  <= 8'h00;
        i_rst_n          <= 1'b0;
        calm             = 1'b0;
        pressure_on      = 1'b0;
        random_items     = 0;
        bytes_sent       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every operator, space, newline, return with swallowed byte,
        // string, number flushed by an operator, keyword flushed by end of source,
        // illegal byte, return before end of source, unterminated string
        push_text("+-*/=,()<> \n");
        src_q.push_back(CH_CR);
        push_text("x\"a\"9-+if");
        src_q.push_back(CH_NUL);
        src_q.push_back(8'h80);
        src_q.push_back(CH_CR);
        src_q.push_back(CH_NUL);
        push_text("\"z");
        src_q.push_back(CH_NUL);
        drain_source();

        while (random_items < RANDOM_ITEMS) begin
            calm = (random_items >= 500 && random_items < 800);
            if (random_items >= 1100) begin
                pressure_on = 1'b1;
            end
            add_lexeme();
            drain_source();
        end
        byte_if.valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d source bytes and %0d tokens (%0d keywords)",
            bytes_sent, checked, keywords);
        $display("output held off for %0d cycles once; %0d mismatches, %0d tokens outstanding",
            HOLD_CYCLES, fails, pending);
        if (fails == 0 && pending == 0) begin
            $display("script_token_lexer regression: pass");
        end else begin
            $display("script_token_lexer regression: fail");
        end
        $finish;
    end

endmodule
